// ===== hw/rtl/spk_pkg.sv =====
// Shared types, constants and rotate helpers for the Speck48/96 round-window engine.
package spk_pkg;

	localparam int MAX_ROUNDS = 32;
	localparam int WORD_W     = 24;
	localparam int FIRST_W    = 5;
	localparam int LAST_W     = 6;
	localparam int STOP_W     = $clog2(MAX_ROUNDS + 1);
	// width shared by round indexes, first round and saturated stop round
	localparam int CMP_W      = (STOP_W > LAST_W) ? STOP_W : LAST_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = WORD_W;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CMP_W-1:0]  rnd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_WORD_0  = 3'd0,
		REG_KEY_WORD_1  = 3'd1,
		REG_KEY_WORD_2  = 3'd2,
		REG_KEY_WORD_3  = 3'd3,
		REG_FIRST_ROUND = 3'd4,
		REG_LAST_ROUND  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		word_t plain_left;
		word_t plain_right;
	} in_t;

	typedef struct packed {
		word_t cipher_left;
		word_t cipher_right;
	} out_t;

	// settings seen by every cell
	typedef struct packed {
		word_t key0;
		word_t key1;
		word_t key2;
		word_t key3;
		rnd_t  first;
		rnd_t  stop;
	} cfg_t;

	// data word handed from one cell to the next
	typedef struct packed {
		logic  valid;
		word_t a;
		word_t b;
		word_t rk;
		word_t l0;
		word_t l1;
		word_t l2;
	} link_t;

	function automatic word_t rotr8(input word_t x);
		return {x[7:0], x[WORD_W-1:8]};
	endfunction

	function automatic word_t rotl3(input word_t x);
		return {x[WORD_W-4:0], x[WORD_W-1:WORD_W-3]};
	endfunction

endpackage

// ===== hw/rtl/speck48_96_round_window_encrypt_top.sv =====
// Speck48/96 round-window encryption: a chain of 32 round cells, one request per cycle.
// A request is taken at every clock edge where start is high; busy stays low, so a new
// block can follow in every cycle. Its result appears on result with done high once the
// block has passed through the chain, which holds one register-deep cell per round index,
// each applying its round when the index lies in [first_round, last_round) and always
// stepping the key schedule, which travels down the chain with the block. Results leave
// in request order and must be taken in the cycle done is high. Write the configuration
// only while no request is in flight; there is no clearing pass after reset.
module speck48_96_round_window_encrypt_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  spk_pkg::in_t                     req,
	output logic                             done,
	output spk_pkg::out_t                    result,
	input  logic                             cfg_we,
	input  logic [spk_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spk_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	spk_pkg::cfg_t  cfg;
	spk_pkg::link_t link [spk_pkg::MAX_ROUNDS+1];

	spk_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign busy = 1'b0;

	always_comb begin
		link[0].valid = start;
		link[0].a     = req.plain_left;
		link[0].b     = req.plain_right;
		link[0].rk    = cfg.key0;
		link[0].l0    = cfg.key1;
		link[0].l1    = cfg.key2;
		link[0].l2    = cfg.key3;
	end

	for (genvar i = 0; i < spk_pkg::MAX_ROUNDS; i++) begin : g_cell
		spk_round_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (spk_pkg::CMP_W'(i)),
			.cfg    (cfg),
			.din    (link[i]),
			.dout   (link[i+1])
		);
	end

	assign done                = link[spk_pkg::MAX_ROUNDS].valid;
	assign result.cipher_left  = link[spk_pkg::MAX_ROUNDS].a;
	assign result.cipher_right = link[spk_pkg::MAX_ROUNDS].b;

	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, spk_pkg::MAX_ROUNDS))
		else $error("result strobe without a request");

	a_request_completes: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(spk_pkg::MAX_ROUNDS) done)
		else $error("request dropped in the chain");

	a_stop_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.stop <= spk_pkg::CMP_W'(spk_pkg::MAX_ROUNDS))
		else $error("stop round beyond the chain");

endmodule

// ===== hw/rtl/spk_cfg_regs.sv =====
// Configuration register file: key words and round window with stop saturation.
module spk_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [spk_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spk_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output spk_pkg::cfg_t                    cfg
);

	spk_pkg::word_t                   key0_q;
	spk_pkg::word_t                   key1_q;
	spk_pkg::word_t                   key2_q;
	spk_pkg::word_t                   key3_q;
	logic [spk_pkg::FIRST_W-1:0]      first_q;
	logic [spk_pkg::LAST_W-1:0]       last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q  <= '0;
			key1_q  <= '0;
			key2_q  <= '0;
			key3_q  <= '0;
			first_q <= '0;
			last_q  <= spk_pkg::LAST_W'(23);
		end else if (cfg_we) begin
			case (spk_pkg::cfg_reg_t'(cfg_index))
				spk_pkg::REG_KEY_WORD_0:  key0_q  <= cfg_wdata[spk_pkg::WORD_W-1:0];
				spk_pkg::REG_KEY_WORD_1:  key1_q  <= cfg_wdata[spk_pkg::WORD_W-1:0];
				spk_pkg::REG_KEY_WORD_2:  key2_q  <= cfg_wdata[spk_pkg::WORD_W-1:0];
				spk_pkg::REG_KEY_WORD_3:  key3_q  <= cfg_wdata[spk_pkg::WORD_W-1:0];
				spk_pkg::REG_FIRST_ROUND: first_q <= cfg_wdata[spk_pkg::FIRST_W-1:0];
				spk_pkg::REG_LAST_ROUND:  last_q  <= cfg_wdata[spk_pkg::LAST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.key0  = key0_q;
		cfg.key1  = key1_q;
		cfg.key2  = key2_q;
		cfg.key3  = key3_q;
		cfg.first = spk_pkg::CMP_W'(first_q);
		// clamp stop to MAX_ROUNDS, just past the last cell of the chain
		if (spk_pkg::CMP_W'(last_q) > spk_pkg::CMP_W'(spk_pkg::MAX_ROUNDS))
			cfg.stop = spk_pkg::CMP_W'(spk_pkg::MAX_ROUNDS);
		else
			cfg.stop = spk_pkg::CMP_W'(last_q);
	end

endmodule

// ===== hw/rtl/spk_round_cell.sv =====
// One round cell: a cipher round gated by the window plus one key schedule step.
module spk_round_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  spk_pkg::rnd_t  idx,
	input  spk_pkg::cfg_t  cfg,
	input  spk_pkg::link_t din,
	output spk_pkg::link_t dout
);

	logic           apply;
	spk_pkg::word_t a_rnd;
	spk_pkg::word_t b_rnd;
	spk_pkg::word_t m;
	logic           valid_s1;
	spk_pkg::word_t a_s1;
	spk_pkg::word_t b_s1;
	spk_pkg::word_t rk_s1;
	spk_pkg::word_t l0_s1;
	spk_pkg::word_t l1_s1;
	spk_pkg::word_t l2_s1;

	always_comb begin
		apply = (idx >= cfg.first) && (idx < cfg.stop);
		a_rnd = (spk_pkg::rotr8(din.a) + din.b) ^ din.rk;
		b_rnd = spk_pkg::rotl3(din.b) ^ a_rnd;
		m     = (spk_pkg::rotr8(din.l0) + din.rk) ^ spk_pkg::word_t'(idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= din.valid;
		end
	end

	// hold the block outside the window, advance the schedule always
	always_ff @(posedge clk) begin
		a_s1  <= apply ? a_rnd : din.a;
		b_s1  <= apply ? b_rnd : din.b;
		rk_s1 <= m ^ spk_pkg::rotl3(din.rk);
		l0_s1 <= din.l1;
		l1_s1 <= din.l2;
		l2_s1 <= m;
	end

	always_comb begin
		dout.valid = valid_s1;
		dout.a     = a_s1;
		dout.b     = b_s1;
		dout.rk    = rk_s1;
		dout.l0    = l0_s1;
		dout.l1    = l1_s1;
		dout.l2    = l2_s1;
	end

endmodule

// ===== dv/speck48_96_round_window_encrypt_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the Speck48/96 round-window encryption engine.
module speck48_96_round_window_encrypt_top_tb;

	localparam int LATENCY       = spk_pkg::MAX_ROUNDS;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_BLOCKS  = 60;
	localparam int REPORT_MAX    = 10;
	localparam int WW            = spk_pkg::WORD_W;
	localparam spk_pkg::word_t WORD_ONES = 24'hffffff;
	// indexes past the last register, writes there must be dropped
	localparam logic [spk_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [spk_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           start = 1'b0;
	logic                           busy;
	spk_pkg::in_t                   req = '0;
	logic                           done;
	spk_pkg::out_t                  result;
	logic                           cfg_we = 1'b0;
	logic [spk_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [spk_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	// mirror of the block's registers
	spk_pkg::word_t key_q [4] = '{default: '0};
	logic [4:0]     first_q = '0;
	logic [5:0]     last_q = 6'd23;

	spk_pkg::out_t  cipher_due [$];
	spk_pkg::out_t  due;
	bit             start_held = 1'b0;
	int             blocks_sent = 0;
	int             results_seen = 0;
	int             settings_used = 1;
	int             fail_count = 0;
	int             mismatch_count = 0;
	int             cycle_count = 0;

	speck48_96_round_window_encrypt_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				cipher_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Encrypt one block over the current round window; key schedule runs from round 0.
	function automatic spk_pkg::out_t speck_window_encrypt(spk_pkg::in_t blk);
		spk_pkg::word_t a, b, rk, l0, l1, l2, m, ra;
		int unsigned    stop;
		a    = blk.plain_left;
		b    = blk.plain_right;
		rk   = key_q[0];
		l0   = key_q[1];
		l1   = key_q[2];
		l2   = key_q[3];
		stop = (last_q > spk_pkg::MAX_ROUNDS) ? spk_pkg::MAX_ROUNDS : last_q;
		for (int unsigned i = 0; i < stop; i++) begin
			if (i >= first_q) begin
				ra = {a[7:0], a[WW-1:8]};
				a  = spk_pkg::word_t'(ra + b) ^ rk;
				b  = {b[WW-4:0], b[WW-1:WW-3]} ^ a;
			end
			m  = spk_pkg::word_t'({l0[7:0], l0[WW-1:8]} + rk) ^ spk_pkg::word_t'(i);
			rk = m ^ {rk[WW-4:0], rk[WW-1:WW-3]};
			l0 = l1;
			l1 = l2;
			l2 = m;
		end
		return '{cipher_left: a, cipher_right: b};
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned rand_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic spk_pkg::in_t rand_block();
		return '{plain_left: spk_pkg::word_t'($urandom),
			plain_right: spk_pkg::word_t'($urandom)};
	endfunction

	task automatic write_reg(input logic [spk_pkg::CFG_IDX_W-1:0] idx,
		input logic [spk_pkg::CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_wdata <= data;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			spk_pkg::REG_KEY_WORD_0:  key_q[0] = data;
			spk_pkg::REG_KEY_WORD_1:  key_q[1] = data;
			spk_pkg::REG_KEY_WORD_2:  key_q[2] = data;
			spk_pkg::REG_KEY_WORD_3:  key_q[3] = data;
			spk_pkg::REG_FIRST_ROUND: first_q = data[4:0];
			spk_pkg::REG_LAST_ROUND:  last_q = data[5:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_keys(input spk_pkg::word_t k0, input spk_pkg::word_t k1,
		input spk_pkg::word_t k2, input spk_pkg::word_t k3);
		write_reg(spk_pkg::REG_KEY_WORD_0, k0);
		write_reg(spk_pkg::REG_KEY_WORD_1, k1);
		write_reg(spk_pkg::REG_KEY_WORD_2, k2);
		write_reg(spk_pkg::REG_KEY_WORD_3, k3);
	endtask

	task automatic set_window(input spk_pkg::word_t first_data,
		input spk_pkg::word_t last_data);
		write_reg(spk_pkg::REG_FIRST_ROUND, first_data);
		write_reg(spk_pkg::REG_LAST_ROUND, last_data);
		settings_used++;
	endtask

	// Hold the request until taken; keep start high when the next one follows at once.
	task automatic issue_block(input spk_pkg::in_t blk, input int unsigned gap);
		req   <= blk;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		cipher_due.push_back(speck_window_encrypt(blk));
		blocks_sent++;
		start_held = (gap == 0);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_pipeline_empty();
		if (start_held) begin
			start <= 1'b0;
			start_held = 1'b0;
		end
		while (cipher_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_reset_defaults();
		issue_block('{plain_left: '0, plain_right: '0}, rand_gap());
		issue_block('{plain_left: WORD_ONES, plain_right: WORD_ONES}, 0);
		issue_block('{plain_left: WORD_ONES, plain_right: '0}, 0);
		issue_block('{plain_left: '0, plain_right: WORD_ONES}, rand_gap());
		issue_block('{plain_left: 24'h800000, plain_right: 24'h000001}, 0);
		wait_pipeline_empty();
	endtask

	task automatic test_published_vector();
		set_keys(24'h020100, 24'h0a0908, 24'h121110, 24'h1a1918);
		issue_block('{plain_left: 24'h6d2073, plain_right: 24'h696874}, 0);
		issue_block('{plain_left: 24'h6d2073, plain_right: 24'h696874}, 0);
		wait_pipeline_empty();
	endtask

	task automatic test_window_edges();
		// empty windows, zero stop, full window, last round only, saturation, junk upper bits
		spk_pkg::word_t win_first [9] = '{24'd5, 24'd20, 24'd0, 24'd0, 24'd31, 24'd31,
			24'd0, 24'hABCDE3, 24'd0};
		spk_pkg::word_t win_last [9] = '{24'd5, 24'd3, 24'd0, 24'd32, 24'd32, 24'd63,
			24'd40, 24'h5A5A4A, 24'd33};
		for (int n = 0; n < 9; n++) begin
			if (n == 8)
				set_keys(WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES);
			set_window(win_first[n], win_last[n]);
			issue_block(rand_block(), 0);
			wait_pipeline_empty();
		end
		write_reg(REG_SPARE_LO, spk_pkg::word_t'($urandom));
		write_reg(REG_SPARE_HI, spk_pkg::word_t'($urandom));
		issue_block(rand_block(), 0);
		wait_pipeline_empty();
	endtask

	task automatic test_random_traffic();
		spk_pkg::word_t f, l, junk_f, junk_l;
		int             pick;
		bit             dense;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			pick = int'($urandom_range(0, 7));
			if (pick == 0)
				set_keys('0, '0, '0, '0);
			else if (pick == 1)
				set_keys(WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES);
			else
				set_keys(spk_pkg::word_t'($urandom), spk_pkg::word_t'($urandom),
					spk_pkg::word_t'($urandom), spk_pkg::word_t'($urandom));
			// force the extreme windows first, then draw mostly non-empty ones
			pick = (phase < 5) ? phase : int'($urandom_range(5, 12));
			case (pick)
				0: begin f = 24'd0; l = 24'd32; end
				1: begin f = 24'd31; l = 24'd32; end
				2: begin f = 24'd0; l = 24'd0; end
				3: begin f = 24'd31; l = 24'd63; end
				4: begin
					f = spk_pkg::word_t'($urandom_range(0, 31));
					l = spk_pkg::word_t'($urandom_range(33, 63));
				end
				5: begin
					f = spk_pkg::word_t'($urandom_range(0, 31));
					l = spk_pkg::word_t'($urandom_range(0, 63));
				end
				default: begin
					f = spk_pkg::word_t'($urandom_range(0, 31));
					l = spk_pkg::word_t'($urandom_range(32'(f) + 1, 32));
				end
			endcase
			junk_f = $urandom_range(0, 1) ? (spk_pkg::word_t'($urandom) & 24'hffffe0) : '0;
			junk_l = $urandom_range(0, 1) ? (spk_pkg::word_t'($urandom) & 24'hffffc0) : '0;
			set_window(junk_f | f, junk_l | l);
			dense = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_BLOCKS; n++)
				issue_block(rand_block(), dense ? 0 : rand_gap());
			wait_pipeline_empty();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (cipher_due.size() == 0) begin
				fail_count++;
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("%0t: result %h/%h with no request pending", $realtime,
						result.cipher_left, result.cipher_right);
			end else begin
				due = cipher_due.pop_front();
				if (result.cipher_left !== due.cipher_left ||
				    result.cipher_right !== due.cipher_right) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("%0t: left exp %h got %h, right exp %h got %h", $realtime,
							due.cipher_left, result.cipher_left,
							due.cipher_right, result.cipher_right);
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_published_vector();
		test_window_edges();
		test_random_traffic();
		repeat (LATENCY + 8) @(posedge clk);
		$display("Sent %0d blocks over %0d key/window settings, %0d ciphertexts checked",
			blocks_sent, settings_used, results_seen);
		$display("Failures: %0d in %0d cycles", fail_count, cycle_count);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
